/* hdl/dsmc_pkg.sv */
// shared types and constants of the dual soil moisture calibrator
package dsmc_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 18;
   localparam int PCT_W      = 7;
   localparam int HALF_W     = 8;
   localparam int DIVIDEND_W = 19;
   localparam int DIVISOR_W  = 12;
   localparam int STEP_W     = $clog2(DIVIDEND_W);
   // reciprocal scale for the averages: sums stay below 2**SUM_W, at most 64 samples
   localparam int RECIP_SHIFT = SUM_W + 6;

   localparam logic [SAMPLE_W-1:0] VALID_LOW   = 12'd100;
   localparam logic [SAMPLE_W-1:0] VALID_HIGH  = 12'd4090;
   localparam logic [SAMPLE_W-1:0] DRY_RESET   = 12'd2800;
   localparam logic [SAMPLE_W-1:0] WET_RESET   = 12'd1200;
   localparam logic [PCT_W-1:0]    PERCENT_FULL = 7'd100;

   typedef enum logic [0:0] {
      CSR_DRY_LEVEL = 1'b0,
      CSR_WET_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      DIV_MAP_A = 1'b0,
      DIV_MAP_B = 1'b1
   } div_sel_type;

   typedef enum logic [2:0] {
      ST_ACCUM   = 3'd0,
      ST_AVERAGE = 3'd1,
      ST_SCALE   = 3'd2,
      ST_MAP_GO  = 3'd3,
      ST_MAP_A   = 3'd4,
      ST_MAP_B   = 3'd5
   } ctrl_state_type;

   typedef struct packed {
      logic        accumulate;
      logic        clear_acc;
      logic        latch_avg;
      logic        div_start;
      div_sel_type div_sel;
      logic        latch_scale;
      logic        load_rsp;
   } dsmc_cmd_type;

   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic rsp_free;
   } dsmc_status_type;

endpackage

/* hdl/dsmc_channels.sv */
// request and response channel interfaces of the calibrator
interface dsmc_req_if;
   logic                           valid;
   logic                           ready;
   logic [dsmc_pkg::SAMPLE_W-1:0]  probe_a_sample;
   logic [dsmc_pkg::SAMPLE_W-1:0]  probe_b_sample;

   modport source (output valid, output probe_a_sample, output probe_b_sample, input ready);
   modport sink (input valid, input probe_a_sample, input probe_b_sample, output ready);
endinterface

interface dsmc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dsmc_pkg::SAMPLE_W-1:0]  mean_raw_a;
   logic [dsmc_pkg::SAMPLE_W-1:0]  mean_raw_b;
   logic [dsmc_pkg::PCT_W-1:0]     moisture_a;
   logic [dsmc_pkg::PCT_W-1:0]     moisture_b;
   logic                           valid_a;
   logic                           valid_b;
   logic                           any_valid;
   logic [dsmc_pkg::HALF_W-1:0]    mean_moisture_half;

   modport source (output valid, output mean_raw_a, output mean_raw_b, output moisture_a,
                   output moisture_b, output valid_a, output valid_b, output any_valid,
                   output mean_moisture_half, input ready);
   modport sink (input valid, input mean_raw_a, input mean_raw_b, input moisture_a,
                 input moisture_b, input valid_a, input valid_b, input any_valid,
                 input mean_moisture_half, output ready);
endinterface

/* hdl/dual_soil_moisture_calibrator.sv */
// top level of the dual soil moisture calibrator
//
// req_chan carries one pair of 12-bit samples per transfer, one from each probe.
// While a reading builds up, a pair is taken every cycle that valid is high.
// The SAMPLES-th pair closes the reading: ready then stays low until the result
// is loaded. The two averages come from a reciprocal multiply, then one shared
// divider, one quotient bit a cycle, runs the two 19-bit percentage maps in turn;
// rsp_chan valid rises when the result is loaded into the output register.
// One result leaves for every SAMPLES request transfers.
// A stalled response holds its fields; the next reading keeps accumulating
// behind it, and only the hand-over of the following result waits for it,
// with ready held low until the output register frees.
// csr_we writes dry_level (index 0) or wet_level (index 1) from csr_wdata;
// write them only while no reading is in progress.
// Reset clears the sums, the sample count and the response valid, and loads
// dry_level 2800 and wet_level 1200.
module dual_soil_moisture_calibrator #(
   parameter int SAMPLES = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   dsmc_req_if.sink                      req_chan,
   dsmc_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [dsmc_pkg::SAMPLE_W-1:0] csr_wdata
);

   dsmc_pkg::dsmc_cmd_type    cmd;
   dsmc_pkg::dsmc_status_type status;
   logic                      ctrl_ready;

   dsmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_chan.ready = ctrl_ready;

   dsmc_datapath #(
      .SAMPLES (SAMPLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_we             (csr_we),
      .csr_index          (dsmc_pkg::csr_index_type'(csr_index)),
      .csr_wdata          (csr_wdata),
      .probe_a_sample     (req_chan.probe_a_sample),
      .probe_b_sample     (req_chan.probe_b_sample),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .mean_raw_a         (rsp_chan.mean_raw_a),
      .mean_raw_b         (rsp_chan.mean_raw_b),
      .moisture_a         (rsp_chan.moisture_a),
      .moisture_b         (rsp_chan.moisture_b),
      .valid_a            (rsp_chan.valid_a),
      .valid_b            (rsp_chan.valid_b),
      .any_valid          (rsp_chan.any_valid),
      .mean_moisture_half (rsp_chan.mean_moisture_half)
   );

endmodule

/* hdl/dsmc_divider.sv */
// iterative restoring divider, one quotient bit per cycle
module dsmc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dsmc_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [dsmc_pkg::DIVISOR_W-1:0]    divisor,
   output logic [dsmc_pkg::DIVIDEND_W-1:0]   quotient,
   output logic                              done
);

   logic [dsmc_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [dsmc_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [dsmc_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [dsmc_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;

   logic [dsmc_pkg::DIVISOR_W:0]    partial;
   logic [dsmc_pkg::DIVISOR_W:0]    trial;
   logic                            fits;

   always_comb begin
      partial = {rem_ff, quo_ff[dsmc_pkg::DIVIDEND_W-1]};
      trial   = partial - {1'b0, dvs_ff};
      fits    = !trial[dsmc_pkg::DIVISOR_W];

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = dsmc_pkg::STEP_W'(dsmc_pkg::DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[dsmc_pkg::DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial[dsmc_pkg::DIVISOR_W-1:0] : partial[dsmc_pkg::DIVISOR_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* hdl/dsmc_ctrl.sv */
// sequencing state machine: accumulate, average, map and hand over a result
module dsmc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dsmc_pkg::dsmc_status_type   status,
   output dsmc_pkg::dsmc_cmd_type      cmd
);

   dsmc_pkg::ctrl_state_type state_ff, state_in;
   logic                     finish_ff, finish_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dsmc_pkg::ST_ACCUM;
         finish_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         finish_ff <= finish_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      finish_in   = finish_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.div_sel = dsmc_pkg::DIV_MAP_A;
      unique case (state_ff)
         dsmc_pkg::ST_ACCUM: begin
            if (finish_ff) begin
               // last quotient is in, wait for a free output register
               if (status.rsp_free) begin
                  cmd.load_rsp = 1'b1;
                  finish_in    = 1'b0;
               end
            end else begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.accumulate = 1'b1;
                  if (status.last_sample) begin
                     state_in = dsmc_pkg::ST_AVERAGE;
                  end
               end
            end
         end
         dsmc_pkg::ST_AVERAGE: begin
            cmd.latch_avg = 1'b1;
            cmd.clear_acc = 1'b1;
            state_in      = dsmc_pkg::ST_SCALE;
         end
         dsmc_pkg::ST_SCALE: begin
            cmd.latch_scale = 1'b1;
            state_in        = dsmc_pkg::ST_MAP_GO;
         end
         dsmc_pkg::ST_MAP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = dsmc_pkg::DIV_MAP_A;
            state_in      = dsmc_pkg::ST_MAP_A;
         end
         dsmc_pkg::ST_MAP_A: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = dsmc_pkg::DIV_MAP_B;
               state_in      = dsmc_pkg::ST_MAP_B;
            end
         end
         dsmc_pkg::ST_MAP_B: begin
            if (status.div_done) begin
               finish_in = 1'b1;
               state_in  = dsmc_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = dsmc_pkg::ST_ACCUM;
         end
      endcase
   end

endmodule

/* hdl/dsmc_datapath.sv */
// accumulators, calibration registers, scaling, shared divider and result register
module dsmc_datapath #(
   parameter int SAMPLES = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dsmc_pkg::dsmc_cmd_type            cmd,
   output dsmc_pkg::dsmc_status_type         status,
   input  logic                              csr_we,
   input  dsmc_pkg::csr_index_type           csr_index,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]     csr_wdata,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]     probe_a_sample,
   input  logic [dsmc_pkg::SAMPLE_W-1:0]     probe_b_sample,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [dsmc_pkg::SAMPLE_W-1:0]     mean_raw_a,
   output logic [dsmc_pkg::SAMPLE_W-1:0]     mean_raw_b,
   output logic [dsmc_pkg::PCT_W-1:0]        moisture_a,
   output logic [dsmc_pkg::PCT_W-1:0]        moisture_b,
   output logic                              valid_a,
   output logic                              valid_b,
   output logic                              any_valid,
   output logic [dsmc_pkg::HALF_W-1:0]       mean_moisture_half
);

   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int SW    = dsmc_pkg::SAMPLE_W;
   localparam int DW    = dsmc_pkg::DIVIDEND_W;
   localparam int PW    = dsmc_pkg::PCT_W;
   localparam int RS    = dsmc_pkg::RECIP_SHIFT;
   localparam int RW    = RS + 1;
   localparam int PRW   = dsmc_pkg::SUM_W + RW;
   // reciprocal of SAMPLES rounded up, exact for every sum the accumulators hold
   localparam logic [RW-1:0] RECIP = RW'(((2 ** RS) + SAMPLES - 1) / SAMPLES);

   function automatic logic in_band(input logic [SW-1:0] avg);
      in_band = (avg >= dsmc_pkg::VALID_LOW) && (avg <= dsmc_pkg::VALID_HIGH);
   endfunction

   function automatic logic [PW-1:0] clamp_pct(input logic neg, input logic [DW-1:0] quo);
      logic [PW-1:0] pct;
      if (neg) begin
         pct = '0;
      end else if (quo > DW'(dsmc_pkg::PERCENT_FULL)) begin
         pct = dsmc_pkg::PERCENT_FULL;
      end else begin
         pct = quo[PW-1:0];
      end
      clamp_pct = pct;
   endfunction

   // calibration registers
   logic [SW-1:0] dry_ff, dry_in;
   logic [SW-1:0] wet_ff, wet_in;

   always_comb begin
      dry_in = dry_ff;
      wet_in = wet_ff;
      if (csr_we) begin
         unique case (csr_index)
            dsmc_pkg::CSR_DRY_LEVEL: dry_in = csr_wdata;
            dsmc_pkg::CSR_WET_LEVEL: wet_in = csr_wdata;
            default: begin
               dry_in = dry_ff;
            end
         endcase
      end
   end

   // accumulators
   logic [dsmc_pkg::SUM_W-1:0] sum_a_ff, sum_a_in;
   logic [dsmc_pkg::SUM_W-1:0] sum_b_ff, sum_b_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   always_comb begin
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      cnt_in   = cnt_ff;
      priority if (cmd.clear_acc) begin
         sum_a_in = '0;
         sum_b_in = '0;
         cnt_in   = '0;
      end else if (cmd.accumulate) begin
         sum_a_in = sum_a_ff + dsmc_pkg::SUM_W'(probe_a_sample);
         sum_b_in = sum_b_ff + dsmc_pkg::SUM_W'(probe_b_sample);
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   // calibration span, sign and magnitude
   logic [SW:0]   span_diff;
   logic [SW:0]   span_abs;
   logic          span_neg;
   logic          span_zero;

   assign span_diff = {1'b0, wet_ff} - {1'b0, dry_ff};
   assign span_neg  = span_diff[SW];
   assign span_abs  = span_neg ? ((SW + 1)'(0) - span_diff) : span_diff;
   assign span_zero = (span_diff == '0);

   // averages by reciprocal multiply
   logic [PRW-1:0] prod_a, prod_b;
   logic [SW-1:0]  avg_a_ff, avg_a_in;
   logic [SW-1:0]  avg_b_ff, avg_b_in;

   assign prod_a = PRW'(sum_a_ff) * PRW'(RECIP);
   assign prod_b = PRW'(sum_b_ff) * PRW'(RECIP);

   always_comb begin
      avg_a_in = avg_a_ff;
      avg_b_in = avg_b_ff;
      if (cmd.latch_avg) begin
         avg_a_in = prod_a[RS +: SW];
         avg_b_in = prod_b[RS +: SW];
      end
   end

   // scaled offsets from the dry level
   logic [DW-1:0] num_a_ff, num_a_in;
   logic [DW-1:0] num_b_ff, num_b_in;
   logic          neg_a_ff, neg_a_in;
   logic          neg_b_ff, neg_b_in;
   logic [DW-1:0] quo_a_ff, quo_a_in;
   logic [DW-1:0] quo_b_ff, quo_b_in;
   dsmc_pkg::div_sel_type dest_ff, dest_in;

   logic [SW:0]   off_a, off_b;
   logic [SW:0]   mag_a, mag_b;

   assign off_a = {1'b0, avg_a_ff} - {1'b0, dry_ff};
   assign off_b = {1'b0, avg_b_ff} - {1'b0, dry_ff};
   assign mag_a = off_a[SW] ? ((SW + 1)'(0) - off_a) : off_a;
   assign mag_b = off_b[SW] ? ((SW + 1)'(0) - off_b) : off_b;

   always_comb begin
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      neg_a_in = neg_a_ff;
      neg_b_in = neg_b_ff;
      if (cmd.latch_scale) begin
         num_a_in = DW'(mag_a[SW-1:0]) * DW'(dsmc_pkg::PERCENT_FULL);
         num_b_in = DW'(mag_b[SW-1:0]) * DW'(dsmc_pkg::PERCENT_FULL);
         neg_a_in = off_a[SW];
         neg_b_in = off_b[SW];
      end
   end

   // shared divider for the two percentage maps
   logic [DW-1:0]                    div_dividend;
   logic [dsmc_pkg::DIVISOR_W-1:0]   div_divisor;
   logic [DW-1:0]                    div_quotient;
   logic                             div_done;

   assign div_dividend = (cmd.div_sel == dsmc_pkg::DIV_MAP_B) ? num_b_ff : num_a_ff;
   assign div_divisor  = span_abs[SW-1:0];

   dsmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .done     (div_done)
   );

   // quotient goes where the division was started for
   always_comb begin
      dest_in  = cmd.div_start ? cmd.div_sel : dest_ff;
      quo_a_in = quo_a_ff;
      quo_b_in = quo_b_ff;
      if (div_done) begin
         unique case (dest_ff)
            dsmc_pkg::DIV_MAP_A: quo_a_in = div_quotient;
            dsmc_pkg::DIV_MAP_B: quo_b_in = div_quotient;
         endcase
      end
   end

   // result assembly
   logic                    va, vb;
   logic [PW-1:0]           ma, mb;
   logic [dsmc_pkg::HALF_W-1:0] half;

   always_comb begin
      va = in_band(avg_a_ff);
      vb = in_band(avg_b_ff);
      ma = (va && !span_zero) ? clamp_pct(neg_a_ff ^ span_neg, quo_a_ff) : '0;
      mb = (vb && !span_zero) ? clamp_pct(neg_b_ff ^ span_neg, quo_b_ff) : '0;
      priority if (va && vb) begin
         half = dsmc_pkg::HALF_W'(ma) + dsmc_pkg::HALF_W'(mb);
      end else if (va) begin
         half = {ma, 1'b0};
      end else if (vb) begin
         half = {mb, 1'b0};
      end else begin
         half = '0;
      end
   end

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]               mean_a_ff, mean_b_ff;
   logic [PW-1:0]               moist_a_ff, moist_b_ff;
   logic                        va_ff, vb_ff, any_ff;
   logic [dsmc_pkg::HALF_W-1:0] half_ff;

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      avg_a_ff <= avg_a_in;
      avg_b_ff <= avg_b_in;
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      quo_a_ff <= quo_a_in;
      quo_b_ff <= quo_b_in;
      dest_ff  <= dest_in;
      if (cmd.load_rsp) begin
         mean_a_ff  <= avg_a_ff;
         mean_b_ff  <= avg_b_ff;
         moist_a_ff <= ma;
         moist_b_ff <= mb;
         va_ff      <= va;
         vb_ff      <= vb;
         any_ff     <= va || vb;
         half_ff    <= half;
      end
      if (reset) begin
         dry_ff       <= dsmc_pkg::DRY_RESET;
         wet_ff       <= dsmc_pkg::WET_RESET;
         sum_a_ff     <= '0;
         sum_b_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dry_ff       <= dry_in;
         wet_ff       <= wet_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.last_sample = (cnt_ff == CNT_W'(SAMPLES - 1));
   assign status.div_done    = div_done;
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign mean_raw_a         = mean_a_ff;
   assign mean_raw_b         = mean_b_ff;
   assign moisture_a         = moist_a_ff;
   assign moisture_b         = moist_b_ff;
   assign valid_a            = va_ff;
   assign valid_b            = vb_ff;
   assign any_valid          = any_ff;
   assign mean_moisture_half = half_ff;

endmodule

/* verif/tb_dual_soil_moisture_calibrator.sv */
// self-checking testbench of the dual soil moisture calibrator
module tb_dual_soil_moisture_calibrator;

   localparam int SAMPLES        = 8;
   localparam int MAX_WAIT       = 14;
   localparam int DRAIN_CYCLES   = 120;
   localparam int STALL_LIMIT    = 4000;
   localparam int PHASE_READINGS = 12;
   localparam int FIXED_SETS     = 7;
   localparam int PHASES         = 10;
   localparam int PRINT_LIMIT    = 100;
   localparam int SW             = dsmc_pkg::SAMPLE_W;

   typedef struct packed {
      logic [SW-1:0]                   mean_raw_a;
      logic [SW-1:0]                   mean_raw_b;
      logic [dsmc_pkg::PCT_W-1:0]      moisture_a;
      logic [dsmc_pkg::PCT_W-1:0]      moisture_b;
      logic                            valid_a;
      logic                            valid_b;
      logic                            any_valid;
      logic [dsmc_pkg::HALF_W-1:0]     mean_moisture_half;
   } reading_type;

   class moisture_scoreboard;
      logic [SW-1:0]              dry_level = dsmc_pkg::DRY_RESET;
      logic [SW-1:0]              wet_level = dsmc_pkg::WET_RESET;
      logic [dsmc_pkg::SUM_W-1:0] sum_a = '0;
      logic [dsmc_pkg::SUM_W-1:0] sum_b = '0;
      int                         pairs_in_reading = 0;
      reading_type                readings_due[$];
      int                         errors = 0;
      int                         checked = 0;
      int                         both_valid = 0;
      int                         none_valid = 0;
      int                         flat_span = 0;

      function void set_level(dsmc_pkg::csr_index_type idx, logic [SW-1:0] level);
         case (idx)
            dsmc_pkg::CSR_DRY_LEVEL: dry_level = level;
            dsmc_pkg::CSR_WET_LEVEL: wet_level = level;
            default: ;
         endcase
      endfunction

      // linear map between the two levels, division truncates toward zero
      function logic [dsmc_pkg::PCT_W-1:0] percent_of(logic [SW-1:0] raw);
         int span;
         int pct;
         span = int'(wet_level) - int'(dry_level);
         if (span == 0) return '0;
         pct = ((int'(raw) - int'(dry_level)) * 100) / span;
         if (pct < 0) pct = 0;
         if (pct > 100) pct = 100;
         return dsmc_pkg::PCT_W'(pct);
      endfunction

      function void note_pair(logic [SW-1:0] a, logic [SW-1:0] b);
         reading_type due;
         sum_a = sum_a + dsmc_pkg::SUM_W'(a);
         sum_b = sum_b + dsmc_pkg::SUM_W'(b);
         pairs_in_reading++;
         if (pairs_in_reading < SAMPLES) return;
         due.mean_raw_a = SW'(sum_a / SAMPLES);
         due.mean_raw_b = SW'(sum_b / SAMPLES);
         sum_a = '0;
         sum_b = '0;
         pairs_in_reading = 0;
         due.valid_a = due.mean_raw_a >= dsmc_pkg::VALID_LOW &&
                       due.mean_raw_a <= dsmc_pkg::VALID_HIGH;
         due.valid_b = due.mean_raw_b >= dsmc_pkg::VALID_LOW &&
                       due.mean_raw_b <= dsmc_pkg::VALID_HIGH;
         due.any_valid = due.valid_a || due.valid_b;
         due.moisture_a = due.valid_a ? percent_of(due.mean_raw_a) : '0;
         due.moisture_b = due.valid_b ? percent_of(due.mean_raw_b) : '0;
         if (due.valid_a && due.valid_b)
            due.mean_moisture_half = dsmc_pkg::HALF_W'(due.moisture_a) +
                                     dsmc_pkg::HALF_W'(due.moisture_b);
         else if (due.valid_a)
            due.mean_moisture_half = {due.moisture_a, 1'b0};
         else if (due.valid_b)
            due.mean_moisture_half = {due.moisture_b, 1'b0};
         else
            due.mean_moisture_half = '0;
         if (due.valid_a && due.valid_b) both_valid++;
         if (!due.any_valid) none_valid++;
         if (dry_level == wet_level) flat_span++;
         readings_due.push_back(due);
      endfunction

      task flag(string what);
         errors++;
         if (errors <= PRINT_LIMIT) $display("error: %s", what);
      endtask

      task cmp_field(string name, logic [SW-1:0] got, logic [SW-1:0] want);
         if (got !== want)
            flag($sformatf("reading %0d field %s is %0d, want %0d", checked, name, got, want));
      endtask

      task check_reading(reading_type got);
         reading_type want;
         if (readings_due.size() == 0) begin
            flag($sformatf("reading with nothing pending: %p", got));
            return;
         end
         want = readings_due.pop_front();
         cmp_field("mean_raw_a", got.mean_raw_a, want.mean_raw_a);
         cmp_field("mean_raw_b", got.mean_raw_b, want.mean_raw_b);
         cmp_field("moisture_a", got.moisture_a, want.moisture_a);
         cmp_field("moisture_b", got.moisture_b, want.moisture_b);
         cmp_field("valid_a", got.valid_a, want.valid_a);
         cmp_field("valid_b", got.valid_b, want.valid_b);
         cmp_field("any_valid", got.any_valid, want.any_valid);
         cmp_field("mean_moisture_half", got.mean_moisture_half, want.mean_moisture_half);
         checked++;
      endtask
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we;
   dsmc_pkg::csr_index_type csr_index;
   logic [SW-1:0]           csr_wdata;
   bit                      req_idles = 1'b1;
   bit                      rsp_idles = 1'b1;
   int                      pairs_sent = 0;
   int                      settings_used = 0;
   int                      idle_cycles = 0;

   moisture_scoreboard sb = new;

   dsmc_req_if req_chan();
   dsmc_rsp_if rsp_chan();

   dual_soil_moisture_calibrator #(.SAMPLES(SAMPLES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   task automatic send_pair(input logic [SW-1:0] a, input logic [SW-1:0] b);
      int gap;
      gap = req_idles ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.probe_a_sample <= a;
      req_chan.probe_b_sample <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic write_levels(input logic [SW-1:0] dry, input logic [SW-1:0] wet);
      csr_we <= 1'b1;
      csr_index <= dsmc_pkg::CSR_DRY_LEVEL;
      csr_wdata <= dry;
      @(posedge clock);
      sb.set_level(dsmc_pkg::CSR_DRY_LEVEL, dry);
      csr_index <= dsmc_pkg::CSR_WET_LEVEL;
      csr_wdata <= wet;
      @(posedge clock);
      sb.set_level(dsmc_pkg::CSR_WET_LEVEL, wet);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // where a probe's samples gather in one reading: anywhere, at a validity edge,
   // or around the calibration span
   task automatic pick_spread(output int centre, output int spread);
      int lo;
      int hi;
      lo = (sb.dry_level < sb.wet_level) ? sb.dry_level : sb.wet_level;
      hi = (sb.dry_level < sb.wet_level) ? sb.wet_level : sb.dry_level;
      lo = (lo > 150) ? lo - 150 : 0;
      hi = (hi < 3945) ? hi + 150 : 4095;
      case ($urandom_range(0, 9))
         0, 1: begin
            centre = 2048;
            spread = 2048;
         end
         2, 3: begin
            centre = $urandom_range(0, 1) ? int'(dsmc_pkg::VALID_LOW)
                                          : int'(dsmc_pkg::VALID_HIGH);
            spread = 12;
         end
         default: begin
            centre = $urandom_range(lo, hi);
            spread = 25;
         end
      endcase
   endtask

   function automatic logic [SW-1:0] jitter(int centre, int spread);
      int level;
      level = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      return SW'(level);
   endfunction

   task automatic random_reading();
      int ctr_a;
      int spr_a;
      int ctr_b;
      int spr_b;
      pick_spread(ctr_a, spr_a);
      pick_spread(ctr_b, spr_b);
      repeat (SAMPLES) send_pair(jitter(ctr_a, spr_a), jitter(ctr_b, spr_b));
   endtask

   // the last reading of a phase always closes with a result, then allow the divider to go quiet
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (sb.readings_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [SW-1:0] dry_set[FIXED_SETS];
      logic [SW-1:0] wet_set[FIXED_SETS];
      dry_set = '{12'd0, 12'd4095, 12'd2000, 12'd1200, 12'd0, 12'd4095, 12'd1000};
      wet_set = '{12'd4095, 12'd0, 12'd2000, 12'd2800, 12'd0, 12'd4095, 12'd1001};
      req_chan.valid <= 1'b0;
      req_chan.probe_a_sample <= '0;
      req_chan.probe_b_sample <= '0;
      csr_we <= 1'b0;
      csr_index <= dsmc_pkg::CSR_DRY_LEVEL;
      csr_wdata <= '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset levels: both probes out of range, then both at the validity edges
      // (saturating high and low), then one probe valid
      for (int i = 0; i < SAMPLES; i++) send_pair(12'd0, 12'd4095);
      for (int i = 0; i < SAMPLES; i++) send_pair(dsmc_pkg::VALID_LOW, dsmc_pkg::VALID_HIGH);
      for (int i = 0; i < SAMPLES; i++) send_pair(12'd4091, (i % 2) ? 12'd4095 : 12'd0);
      repeat (PHASE_READINGS) random_reading();
      settle();

      for (int phase = 1; phase <= PHASES; phase++) begin
         req_idles = (phase % 3) != 1;
         rsp_idles = (phase % 4) != 2;
         if (phase <= FIXED_SETS)
            write_levels(dry_set[phase-1], wet_set[phase-1]);
         else
            write_levels(SW'($urandom_range(0, 4095)), SW'($urandom_range(0, 4095)));
         repeat (PHASE_READINGS) random_reading();
         settle();
      end

      $display("sent %0d sample pairs under %0d level settings plus the reset levels",
               pairs_sent, settings_used);
      $display("checked %0d readings: %0d with both probes valid, %0d with none, %0d %s",
               sb.checked, sb.both_valid, sb.none_valid, sb.flat_span, "with a flat span");
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idles ? $urandom_range(0, MAX_WAIT) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : monitor
      reading_type got;
      bit          moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            sb.note_pair(req_chan.probe_a_sample, req_chan.probe_b_sample);
            pairs_sent++;
            moved = 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.mean_raw_a         = rsp_chan.mean_raw_a;
            got.mean_raw_b         = rsp_chan.mean_raw_b;
            got.moisture_a         = rsp_chan.moisture_a;
            got.moisture_b         = rsp_chan.moisture_b;
            got.valid_a            = rsp_chan.valid_a;
            got.valid_b            = rsp_chan.valid_b;
            got.any_valid          = rsp_chan.any_valid;
            got.mean_moisture_half = rsp_chan.mean_moisture_half;
            sb.check_reading(got);
            moved = 1'b1;
         end
         // no transfer on either channel for too long means the block has hung
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d readings pending",
                     STALL_LIMIT, sb.readings_due.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

endmodule

/* files.f */
hdl/dsmc_pkg.sv
hdl/dsmc_channels.sv
hdl/dsmc_divider.sv
hdl/dsmc_ctrl.sv
hdl/dsmc_datapath.sv
hdl/dual_soil_moisture_calibrator.sv
verif/tb_dual_soil_moisture_calibrator.sv
